>>> rtl/brvm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the byte-register VM execute unit.
// No dependencies; every other file but brvm_if imports this package.
package brvm_pkg;

    // Storage sizes
    localparam int HEAP_BYTES  = 8192;
    localparam int HEAP_AW     = $clog2(HEAP_BYTES);
    localparam int REG_COUNT   = 256;
    localparam int REG_AW      = $clog2(REG_COUNT);

    // Decoupling queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CODE_LENGTH_RST = 16'd256;

    // Opcode bytes
    localparam logic [7:0] OPC_HALT  = 8'h00;
    localparam logic [7:0] OPC_LOAD  = 8'h10;
    localparam logic [7:0] OPC_STORE = 8'h20;
    localparam logic [7:0] OPC_MOVE  = 8'h30;
    localparam logic [7:0] OPC_IMM   = 8'h40;
    localparam logic [7:0] OPC_ADD   = 8'h50;
    localparam logic [7:0] OPC_SUB   = 8'h60;
    localparam logic [7:0] OPC_GT    = 8'h70;
    localparam logic [7:0] OPC_GE    = 8'h80;
    localparam logic [7:0] OPC_EQ    = 8'h90;
    localparam logic [7:0] OPC_BNZ   = 8'ha0;
    localparam logic [7:0] OPC_JMP   = 8'hb0;
    localparam logic [7:0] OPC_PUTS  = 8'hc0;
    localparam logic [7:0] OPC_GETS  = 8'hd0;

    // Decoded operation class
    typedef enum logic [3:0] {
        OP_HALT, OP_LOAD, OP_STORE, OP_MOVE, OP_IMM, OP_ADD, OP_SUB,
        OP_GT, OP_GE, OP_EQ, OP_BNZ, OP_JMP, OP_STRIO, OP_BAD
    } t_op;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_OP     = 3'd1,
        ST_BAD_HEAP   = 3'd2,
        ST_BAD_TARGET = 3'd3,
        ST_STRING_IO  = 3'd4
    } t_status;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_READ,
        BK_EXEC,
        BK_LOAD
    } t_back_state;

    // One decoded instruction
    typedef struct packed {
        t_op        op;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } t_uop;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_uop uop;
    } t_qhead;

endpackage

>>> rtl/brvm_if.sv
`timescale 1ns / 1ps
// Channel interfaces: instruction in, result out, configuration write.
// Depends on nothing beyond plain logic types.

interface brvm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] opcode;
    logic [7:0] operand_one;
    logic [7:0] operand_two;
    logic [7:0] operand_three;

    modport source (output valid, opcode, operand_one, operand_two, operand_three,
                    input ready);
    modport sink   (input valid, opcode, operand_one, operand_two, operand_three,
                    output ready);
endinterface

interface brvm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] next_pc;
    logic [31:0] written_value;
    logic        stopped;
    logic [2:0]  status;

    modport source (output valid, next_pc, written_value, stopped, status,
                    input ready);
    modport sink   (input valid, next_pc, written_value, stopped, status,
                    output ready);
endinterface

interface brvm_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_length;

    modport source (output valid, code_length, input ready);
    modport sink   (input valid, code_length, output ready);
endinterface

>>> rtl/brvm_front.sv
`timescale 1ns / 1ps
// Front end: accepts instruction beats, decodes the opcode, queues the result.
// Depends on brvm_pkg and brvm_in_if.
module brvm_front
    import brvm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    brvm_in_if.sink      i_instr,
    output t_qhead       o_head,
    input  logic         i_pop
);

    t_uop              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_count;
    t_op               dec_op;
    logic              push;

    // Opcode decode
    always_comb begin
        unique case (i_instr.opcode) inside
            OPC_HALT:           dec_op = OP_HALT;
            OPC_LOAD:           dec_op = OP_LOAD;
            OPC_STORE:          dec_op = OP_STORE;
            OPC_MOVE:           dec_op = OP_MOVE;
            OPC_IMM:            dec_op = OP_IMM;
            OPC_ADD:            dec_op = OP_ADD;
            OPC_SUB:            dec_op = OP_SUB;
            OPC_GT:             dec_op = OP_GT;
            OPC_GE:             dec_op = OP_GE;
            OPC_EQ:             dec_op = OP_EQ;
            OPC_BNZ:            dec_op = OP_BNZ;
            OPC_JMP:            dec_op = OP_JMP;
            OPC_PUTS, OPC_GETS: dec_op = OP_STRIO;
            default:            dec_op = OP_BAD;
        endcase
    end

    assign i_instr.ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign push          = i_instr.valid && i_instr.ready;

    assign o_head.valid  = (r_count != '0);
    assign o_head.uop    = r_q[r_rptr];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= '{op: dec_op, a: i_instr.operand_one,
                             b: i_instr.operand_two, c: i_instr.operand_three};
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/brvm_back.sv
`timescale 1ns / 1ps
// Back end: register file, heap, program counter and the execute sequencer.
// Depends on brvm_pkg, brvm_out_if and brvm_cfg_if.
module brvm_back
    import brvm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_qhead       i_head,
    output logic         o_pop,
    brvm_cfg_if.sink     i_cfg,
    brvm_out_if.source   o_res
);

    // Control state
    t_back_state         r_state, n_state;
    logic [15:0]         r_pc, n_pc;
    logic                r_running, n_running;
    logic [15:0]         r_code_length;
    t_uop                r_uop;

    // Register file: data memory plus per-entry valid bits (invalid reads as zero)
    logic [31:0]         rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_rf_valid;
    logic [31:0]         r_rd_x, r_rd_y;
    logic                r_vld_x, r_vld_y;
    logic [REG_AW-1:0]   rd_addr_x, rd_addr_y;
    logic                rd_en;
    logic                rf_we;
    logic [31:0]         rf_wdata;

    // Heap
    logic [7:0]          heap_mem [HEAP_BYTES];
    logic [7:0]          r_heap_q;
    logic                heap_we, heap_re;

    // Output register
    logic                r_out_valid;
    logic [15:0]         r_out_pc;
    logic [31:0]         r_out_wval;
    logic                r_out_stopped;
    t_status             r_out_status;
    logic                out_load;
    logic [15:0]         out_pc;
    logic [31:0]         out_wval;
    logic                out_stopped;
    t_status             out_status;
    logic                out_free;

    // Execute results
    logic [31:0]         val_x, val_y;
    logic [15:0]         pc_inc;
    logic                ex_stop, ex_writes;
    t_status             ex_status;
    logic [15:0]         ex_next;
    logic [31:0]         ex_wval;
    logic [7:0]          br_target;

    assign i_cfg.ready = 1'b1;

    // Code length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_length <= CODE_LENGTH_RST;
        end else if (i_cfg.valid) begin
            r_code_length <= i_cfg.code_length;
        end
    end

    // Read ports: x carries the address/tested register, y the second operand
    always_comb begin
        rd_addr_x = ((i_head.uop.op == OP_STORE) || (i_head.uop.op == OP_BNZ))
                    ? i_head.uop.a : i_head.uop.b;
        rd_addr_y = (i_head.uop.op == OP_STORE) ? i_head.uop.b : i_head.uop.c;
    end

    assign val_x  = r_vld_x ? r_rd_x : '0;
    assign val_y  = r_vld_y ? r_rd_y : '0;
    assign pc_inc = r_pc + 16'd1;

    // Operation evaluation on the registered operands
    always_comb begin
        ex_stop   = 1'b0;
        ex_status = ST_OK;
        ex_writes = 1'b0;
        ex_wval   = '0;
        ex_next   = pc_inc;
        br_target = (val_x != '0) ? r_uop.b : r_uop.c;
        unique case (r_uop.op)
            OP_HALT: ex_stop = 1'b1;
            OP_LOAD, OP_STORE: begin
                if (val_x >= 32'(HEAP_BYTES)) begin
                    ex_stop   = 1'b1;
                    ex_status = ST_BAD_HEAP;
                end
            end
            OP_MOVE: begin
                ex_writes = 1'b1;
                ex_wval   = val_x;
            end
            OP_IMM: begin
                ex_writes = 1'b1;
                ex_wval   = {24'd0, r_uop.b};
            end
            OP_ADD: begin
                ex_writes = 1'b1;
                ex_wval   = val_x + val_y;
            end
            OP_SUB: begin
                ex_writes = 1'b1;
                ex_wval   = val_x - val_y;
            end
            OP_GT: begin
                ex_writes = 1'b1;
                ex_wval   = {31'd0, val_x > val_y};
            end
            OP_GE: begin
                ex_writes = 1'b1;
                ex_wval   = {31'd0, val_x >= val_y};
            end
            OP_EQ: begin
                ex_writes = 1'b1;
                ex_wval   = {31'd0, val_x == val_y};
            end
            OP_BNZ: begin
                if ({8'd0, br_target} >= r_code_length) begin
                    ex_stop   = 1'b1;
                    ex_status = ST_BAD_TARGET;
                end else begin
                    ex_next = {8'd0, br_target};
                end
            end
            OP_JMP: ex_next = {8'd0, r_uop.b};
            OP_STRIO: begin
                ex_stop   = 1'b1;
                ex_status = ST_STRING_IO;
            end
            default: begin
                ex_stop   = 1'b1;
                ex_status = ST_BAD_OP;
            end
        endcase
    end

    assign out_free = !r_out_valid || o_res.ready;

    // Sequencer: read operands, execute/write back, optional heap load beat
    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_running   = r_running;
        o_pop       = 1'b0;
        rd_en       = 1'b0;
        rf_we       = 1'b0;
        rf_wdata    = ex_wval;
        heap_we     = 1'b0;
        heap_re     = 1'b0;
        out_load    = 1'b0;
        out_pc      = r_pc;
        out_wval    = '0;
        out_stopped = 1'b1;
        out_status  = ST_OK;
        unique case (r_state)
            BK_READ: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    rd_en   = 1'b1;
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (out_free) begin
                    if (!r_running) begin
                        // machine stopped: report and drop the item
                        out_load = 1'b1;
                        n_state  = BK_READ;
                    end else if (ex_stop) begin
                        out_load   = 1'b1;
                        out_status = ex_status;
                        n_running  = 1'b0;
                        n_state    = BK_READ;
                    end else if (r_uop.op == OP_LOAD) begin
                        heap_re = 1'b1;
                        n_state = BK_LOAD;
                    end else begin
                        out_load    = 1'b1;
                        rf_we       = ex_writes;
                        heap_we     = (r_uop.op == OP_STORE);
                        n_pc        = ex_next;
                        out_pc      = ex_next;
                        out_wval    = ex_wval;
                        out_stopped = 1'b0;
                        n_state     = BK_READ;
                    end
                end
            end
            BK_LOAD: begin
                if (out_free) begin
                    rf_we       = 1'b1;
                    rf_wdata    = {24'd0, r_heap_q};
                    out_load    = 1'b1;
                    n_pc        = pc_inc;
                    out_pc      = pc_inc;
                    out_wval    = {24'd0, r_heap_q};
                    out_stopped = 1'b0;
                    n_state     = BK_READ;
                end
            end
            default: n_state = BK_READ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_READ;
            r_pc        <= '0;
            r_running   <= 1'b1;
            r_rf_valid  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pc      <= n_pc;
            r_running <= n_running;
            if (rf_we) begin
                r_rf_valid[r_uop.a] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Register file write and registered dual read
    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            rf_mem[r_uop.a] <= rf_wdata;
        end
        if (rd_en) begin
            r_rd_x  <= rf_mem[rd_addr_x];
            r_rd_y  <= rf_mem[rd_addr_y];
            r_vld_x <= r_rf_valid[rd_addr_x];
            r_vld_y <= r_rf_valid[rd_addr_y];
            r_uop   <= i_head.uop;
        end
    end

    // Heap: one address, byte write or registered read
    always_ff @(posedge i_clk) begin
        if (heap_we) begin
            heap_mem[val_x[HEAP_AW-1:0]] <= val_y[7:0];
        end
        if (heap_re) begin
            r_heap_q <= heap_mem[val_x[HEAP_AW-1:0]];
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pc      <= out_pc;
            r_out_wval    <= out_wval;
            r_out_stopped <= out_stopped;
            r_out_status  <= out_status;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.next_pc       = r_out_pc;
    assign o_res.written_value = r_out_wval;
    assign o_res.stopped       = r_out_stopped;
    assign o_res.status        = r_out_status;

endmodule

>>> rtl/byte_register_vm_execute_unit.sv
`timescale 1ns / 1ps
// Top level of the byte-register VM execute unit: front end, queue, back end.
// Depends on brvm_pkg, brvm_if, brvm_front and brvm_back.
//
// Executes one 32-bit instruction per input beat and returns one result beat
// (next_pc, written_value, stopped, status). The back end handles each
// instruction in a register-file read state, then an execute and write-back
// state; a heap load adds a heap read state after execute. A 2-entry queue
// behind the front end and a result register let input beats arrive while a
// result waits. The register file reads as zero after reset through per-entry
// valid bits, so no clearing pass is needed. code_length may be written only
// while the unit is idle. After halt or an error every further instruction is
// answered with stopped set and status ok, until reset.
module byte_register_vm_execute_unit
    import brvm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    brvm_in_if.sink      i_instr,
    brvm_out_if.source   o_result,
    brvm_cfg_if.sink     i_cfg
);

    t_qhead head;
    logic   pop;

    brvm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_instr (i_instr),
        .o_head  (head),
        .i_pop   (pop)
    );

    brvm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .i_cfg   (i_cfg),
        .o_res   (o_result)
    );

endmodule

>>> rtl/brvm_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the execute unit, bound to the top level.
// Depends on brvm_pkg and the top-level ports named in the bind.
module brvm_checker
    import brvm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_next_pc,
    input logic [31:0] i_written_value,
    input logic        i_stopped,
    input logic [2:0]  i_status
);

    logic        r_seen_stop;
    logic [15:0] r_stop_pc;
    logic        out_beat;

    assign out_beat = i_out_valid && i_out_ready;

    // Remember the first stop beat and the pc it reported
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_stop <= 1'b0;
            r_stop_pc   <= '0;
        end else if (out_beat && i_stopped && !r_seen_stop) begin
            r_seen_stop <= 1'b1;
            r_stop_pc   <= i_next_pc;
        end
    end

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_next_pc)
            && $stable(i_written_value) && $stable(i_stopped) && $stable(i_status))
        else $error("result changed while stalled");

    // A stopped result never reports a register write
    a_stop_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_stopped |-> i_written_value == 32'd0)
        else $error("stopped result carries a written value");

    // Error status only comes with a stop
    a_err_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK) |-> i_stopped)
        else $error("error status without stop");

    // After a stop: stopped, ok, same pc for every later beat
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && r_seen_stop |-> i_stopped && (i_status == ST_OK)
            && (i_next_pc == r_stop_pc))
        else $error("machine resumed after stop");

endmodule

bind byte_register_vm_execute_unit brvm_checker u_brvm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_next_pc       (o_result.next_pc),
    .i_written_value (o_result.written_value),
    .i_stopped       (o_result.stopped),
    .i_status        (o_result.status)
);

>>> tb/brvm_exec_monitor.sv
`timescale 1ns / 1ps
// Result monitor for the byte-register VM execute unit: predicts each result
// from accepted instruction and code_length beats and compares field by field.
// Depends on brvm_pkg and the channel interfaces in brvm_if.
module brvm_exec_monitor
    import brvm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    brvm_in_if   instr_ch,
    brvm_out_if  res_ch,
    brvm_cfg_if  cfg_ch,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [15:0] next_pc;
        logic [31:0] written_value;
        logic        stopped;
        t_status     status;
    } t_result;

    // Architectural copy of the machine
    logic [31:0] reg_file [REG_COUNT];
    logic [7:0]  heap_mem [HEAP_BYTES];
    logic [15:0] pc;
    logic        live;
    logic [15:0] code_length;

    t_result expected_results [$];
    int      fails = 0;

    assign o_fail_count = fails;

    // Execute one instruction on the copy and return the result it gives
    function automatic t_result execute_instr(logic [7:0] op, logic [7:0] a,
                                              logic [7:0] b, logic [7:0] c);
        t_result     r;
        logic [15:0] nxt;
        logic [31:0] wv;
        logic [31:0] addr;
        logic [7:0]  tgt;
        t_status     st;
        logic        halt_now;
        logic        wr;
        nxt      = pc + 16'd1;
        wv       = '0;
        st       = ST_OK;
        halt_now = 1'b0;
        wr       = 1'b0;
        r.next_pc       = pc;
        r.written_value = '0;
        r.stopped       = 1'b1;
        r.status        = ST_OK;
        // stopped machine answers everything the same way
        if (!live) begin
            return r;
        end
        case (op)
            OPC_HALT: begin
                halt_now = 1'b1;
            end
            OPC_LOAD: begin
                addr = reg_file[b];
                if (addr >= HEAP_BYTES) begin
                    halt_now = 1'b1;
                    st       = ST_BAD_HEAP;
                end else begin
                    wv = {24'd0, heap_mem[addr[HEAP_AW-1:0]]};
                    wr = 1'b1;
                end
            end
            OPC_STORE: begin
                addr = reg_file[a];
                if (addr >= HEAP_BYTES) begin
                    halt_now = 1'b1;
                    st       = ST_BAD_HEAP;
                end else begin
                    heap_mem[addr[HEAP_AW-1:0]] = reg_file[b][7:0];
                end
            end
            OPC_MOVE: begin wv = reg_file[b]; wr = 1'b1; end
            OPC_IMM:  begin wv = {24'd0, b}; wr = 1'b1; end
            OPC_ADD:  begin wv = reg_file[b] + reg_file[c]; wr = 1'b1; end
            OPC_SUB:  begin wv = reg_file[b] - reg_file[c]; wr = 1'b1; end
            OPC_GT:   begin wv = {31'd0, reg_file[b] >  reg_file[c]}; wr = 1'b1; end
            OPC_GE:   begin wv = {31'd0, reg_file[b] >= reg_file[c]}; wr = 1'b1; end
            OPC_EQ:   begin wv = {31'd0, reg_file[b] == reg_file[c]}; wr = 1'b1; end
            OPC_BNZ: begin
                tgt = (reg_file[a] != 32'd0) ? b : c;
                if ({8'd0, tgt} >= code_length) begin
                    halt_now = 1'b1;
                    st       = ST_BAD_TARGET;
                end else begin
                    nxt = {8'd0, tgt};
                end
            end
            OPC_JMP: begin
                nxt = {8'd0, b};   // not bounded by code_length
            end
            OPC_PUTS, OPC_GETS: begin
                halt_now = 1'b1;
                st       = ST_STRING_IO;
            end
            default: begin
                halt_now = 1'b1;
                st       = ST_BAD_OP;
            end
        endcase
        if (halt_now) begin
            live     = 1'b0;
            r.status = st;
            return r;
        end
        if (wr) begin
            reg_file[a] = wv;
        end
        pc = nxt;
        r.next_pc       = pc;
        r.written_value = wv;
        r.stopped       = 1'b0;
        return r;
    endfunction

    // Watch the three channels; results are compared before new beats are predicted
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) reg_file[i] = '0;
            for (int i = 0; i < HEAP_BYTES; i++) heap_mem[i] = '0;
            pc          = '0;
            live        = 1'b1;
            code_length = CODE_LENGTH_RST;
            expected_results.delete();
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected: next_pc %0d value %0h",
                           res_ch.next_pc, res_ch.written_value);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (res_ch.next_pc !== want.next_pc) begin
                        $error("next_pc: expected %0d, actual %0d",
                               want.next_pc, res_ch.next_pc);
                        fails++;
                    end
                    if (res_ch.written_value !== want.written_value) begin
                        $error("written_value: expected %0h, actual %0h",
                               want.written_value, res_ch.written_value);
                        fails++;
                    end
                    if (res_ch.stopped !== want.stopped) begin
                        $error("stopped: expected %0d, actual %0d",
                               want.stopped, res_ch.stopped);
                        fails++;
                    end
                    if (res_ch.status !== 3'(want.status)) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, res_ch.status);
                        fails++;
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                code_length = cfg_ch.code_length;
            end
            if (instr_ch.valid && instr_ch.ready) begin
                expected_results.push_back(execute_instr(instr_ch.opcode,
                    instr_ch.operand_one, instr_ch.operand_two, instr_ch.operand_three));
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

>>> tb/tb_byte_register_vm_execute_unit.sv
`timescale 1ns / 1ps
// Testbench top for the byte-register VM execute unit: clock, reset, stimulus
// and verdict. Depends on brvm_pkg, brvm_if, the unit and brvm_exec_monitor.
module tb_byte_register_vm_execute_unit
    import brvm_pkg::*;
;

    typedef enum int {
        STOP_HALT, STOP_BAD_OP, STOP_LOAD_RANGE, STOP_STORE_RANGE,
        STOP_TARGET, STOP_PUTS, STOP_GETS, STOP_ZERO_LENGTH
    } t_stop_kind;

    localparam int          PHASES       = 5;
    localparam int          PHASE_ITEMS  = 155;
    localparam int          GAP_PCT [5]  = '{0, 59, 0, 16, 0};
    localparam int          STALL_PCT [5] = '{0, 0, 59, 16, 0};
    localparam int          HOLD_CYCLES  = 150;
    localparam logic [7:0]  ALU_OPS [7]  = '{OPC_MOVE, OPC_IMM, OPC_ADD, OPC_SUB,
                                             OPC_GT, OPC_GE, OPC_EQ};

    logic clk = 1'b0;
    logic rst_n;

    brvm_in_if  instr_ch ();
    brvm_out_if res_ch ();
    brvm_cfg_if cfg_ch ();

    int fail_count;
    int pending;

    int   gap_pct   = 0;
    int   stall_pct = 0;
    logic hold_req  = 1'b0;
    bit   hold_done = 1'b0;
    int   n_items   = 0;

    // What the stimulus knows of the registers, so loads and stores stay legal
    logic [31:0] shadow_val [REG_COUNT];
    bit          shadow_known [REG_COUNT];
    bit          heap_filled [HEAP_BYTES];
    logic [15:0] code_len;

    byte_register_vm_execute_unit i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_instr  (instr_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    brvm_exec_monitor u_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .instr_ch     (instr_ch),
        .res_ch       (res_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off counted here
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                res_ch.ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // One instruction beat, with random gaps before it
    task automatic send_beat(input logic [7:0] op, input logic [7:0] a,
                             input logic [7:0] b, input logic [7:0] c);
        while ($urandom_range(99) < gap_pct) begin
            instr_ch.valid <= 1'b0;
            @(posedge clk);
        end
        instr_ch.valid         <= 1'b1;
        instr_ch.opcode        <= op;
        instr_ch.operand_one   <= a;
        instr_ch.operand_two   <= b;
        instr_ch.operand_three <= c;
        @(posedge clk);
        while (!instr_ch.ready) @(posedge clk);
    endtask

    // Send and track what the registers and heap now hold
    task automatic issue(input logic [7:0] op, input logic [7:0] a,
                         input logic [7:0] b, input logic [7:0] c);
        logic [31:0] v;
        case (op)
            OPC_IMM: begin
                shadow_val[a]   = {24'd0, b};
                shadow_known[a] = 1'b1;
            end
            OPC_MOVE: begin
                shadow_val[a]   = shadow_val[b];
                shadow_known[a] = shadow_known[b];
            end
            OPC_ADD, OPC_SUB: begin
                v = (op == OPC_ADD) ? shadow_val[b] + shadow_val[c]
                                    : shadow_val[b] - shadow_val[c];
                shadow_known[a] = shadow_known[b] && shadow_known[c];
                shadow_val[a]   = v;
            end
            OPC_GT, OPC_GE, OPC_EQ, OPC_LOAD: begin
                shadow_known[a] = 1'b0;
            end
            OPC_STORE: begin
                if (shadow_known[a] && shadow_val[a] < HEAP_BYTES)
                    heap_filled[shadow_val[a][HEAP_AW-1:0]] = 1'b1;
            end
            default: ;
        endcase
        n_items++;
        send_beat(op, a, b, c);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_drained();
        instr_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_code_length(input logic [15:0] v);
        wait_drained();
        cfg_ch.valid       <= 1'b1;
        cfg_ch.code_length <= v;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        code_len = v;
    endtask

    // Build a heap address in dst: high bits doubled up, low byte added from tmp
    task automatic make_pointer(input logic [7:0] dst, input logic [7:0] tmp,
                                input logic [12:0] addr);
        issue(OPC_IMM, dst, {3'd0, addr[12:8]}, 8'($urandom_range(255)));
        repeat (8) issue(OPC_ADD, dst, dst, dst);
        issue(OPC_IMM, tmp, addr[7:0], 8'($urandom_range(255)));
        issue(OPC_ADD, dst, dst, tmp);
    endtask

    function automatic logic [12:0] rand_addr();
        if ($urandom_range(99) < 70) return 13'($urandom_range(63));
        return 13'($urandom_range(HEAP_BYTES - 1));
    endfunction

    // Register holding a known in-range address, optionally one already stored to
    function automatic int find_pointer(bit need_data);
        int idx;
        idx = $urandom_range(REG_COUNT - 1);
        for (int n = 0; n < REG_COUNT; n++) begin
            if (shadow_known[idx] && shadow_val[idx] < HEAP_BYTES &&
                (!need_data || heap_filled[shadow_val[idx][HEAP_AW-1:0]]))
                return idx;
            idx = (idx + 1) % REG_COUNT;
        end
        return -1;
    endfunction

    task automatic new_pointer(output int p);
        p = $urandom_range(REG_COUNT - 1);
        make_pointer(8'(p), 8'((p + $urandom_range(1, REG_COUNT - 1)) % REG_COUNT),
                     rand_addr());
    endtask

    // One short legal sequence with random content
    task automatic random_sequence();
        int         sel;
        int         p;
        int         tmax;
        logic [7:0] op;
        logic [7:0] b;
        logic [7:0] c;
        sel = $urandom_range(99);
        if (sel < 10) begin
            new_pointer(p);
        end else if (sel < 30) begin
            p = find_pointer(1'b0);
            if (p < 0) new_pointer(p);
            issue(OPC_STORE, 8'(p), 8'($urandom_range(255)), 8'($urandom_range(255)));
        end else if (sel < 50) begin
            p = find_pointer(1'b1);
            if (p < 0) begin
                p = find_pointer(1'b0);
                if (p < 0) new_pointer(p);
                issue(OPC_STORE, 8'(p), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
            end
            issue(OPC_LOAD, 8'($urandom_range(255)), 8'(p), 8'($urandom_range(255)));
        end else if (sel < 85) begin
            op = ALU_OPS[$urandom_range(6)];
            b  = 8'($urandom_range(255));
            c  = ($urandom_range(99) < 15) ? b : 8'($urandom_range(255));
            issue(op, 8'($urandom_range(255)), b, c);
        end else if (sel < 93) begin
            // both targets legal, whichever way the test goes
            tmax = (code_len > 16'd256) ? 255 : int'(code_len) - 1;
            issue(OPC_BNZ, 8'($urandom_range(255)), 8'($urandom_range(tmax)),
                  8'($urandom_range(tmax)));
        end else begin
            issue(OPC_JMP, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
        end
    endtask

    // The one stop of the run, its kind left to the seed
    task automatic stop_machine();
        t_stop_kind kind;
        int         p;
        int         cl;
        logic [7:0] op;
        kind = t_stop_kind'($urandom_range(7));
        case (kind)
            STOP_HALT: issue(OPC_HALT, 8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)));
            STOP_BAD_OP: begin
                do op = 8'($urandom_range(255)); while (op[3:0] == 4'd0 && op <= OPC_GETS);
                issue(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
            end
            STOP_LOAD_RANGE, STOP_STORE_RANGE: begin
                // address of at least HEAP_BYTES
                p = $urandom_range(REG_COUNT - 1);
                issue(OPC_IMM, 8'(p), 8'($urandom_range(32, 255)), 8'($urandom_range(255)));
                repeat ($urandom_range(8, 10)) issue(OPC_ADD, 8'(p), 8'(p), 8'(p));
                if (kind == STOP_LOAD_RANGE)
                    issue(OPC_LOAD, 8'($urandom_range(255)), 8'(p), 8'($urandom_range(255)));
                else
                    issue(OPC_STORE, 8'(p), 8'($urandom_range(255)), 8'($urandom_range(255)));
            end
            STOP_TARGET: begin
                cl = $urandom_range(1, 200);
                write_code_length(16'(cl));
                issue(OPC_BNZ, 8'($urandom_range(255)), 8'($urandom_range(cl, 255)),
                      8'($urandom_range(cl, 255)));
            end
            STOP_PUTS: issue(OPC_PUTS, 8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)));
            STOP_GETS: issue(OPC_GETS, 8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)));
            default: begin
                // zero code length: no conditional branch can land
                write_code_length(16'd0);
                issue(OPC_BNZ, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
            end
        endcase
    endtask

    initial begin
        int          phase_end;
        int          waited;
        bit          paused;
        logic [15:0] cl;
        rst_n                  = 1'b0;
        instr_ch.valid         = 1'b0;
        instr_ch.opcode        = '0;
        instr_ch.operand_one   = '0;
        instr_ch.operand_two   = '0;
        instr_ch.operand_three = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.code_length     = '0;
        for (int i = 0; i < REG_COUNT; i++) begin
            shadow_val[i]   = '0;
            shadow_known[i] = 1'b1;
        end
        code_len = CODE_LENGTH_RST;
        paused   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, every non-stopping operation, top heap address
        issue(OPC_IMM, 8'hff, 8'hff, 8'hff);
        issue(OPC_MOVE, 8'hfe, 8'hff, 8'h00);
        make_pointer(8'd1, 8'd2, 13'h1fff);
        issue(OPC_STORE, 8'd1, 8'hff, 8'h00);
        issue(OPC_LOAD, 8'd3, 8'd1, 8'hff);
        issue(OPC_SUB, 8'd4, 8'd0, 8'hff);
        issue(OPC_ADD, 8'd5, 8'd4, 8'd4);
        issue(OPC_GT, 8'd6, 8'd4, 8'hff);
        issue(OPC_GE, 8'd7, 8'hff, 8'hfe);
        issue(OPC_EQ, 8'd8, 8'd0, 8'd5);
        issue(OPC_BNZ, 8'hff, 8'd5, 8'd7);
        issue(OPC_BNZ, 8'd0, 8'd5, 8'd7);
        issue(OPC_JMP, 8'h00, 8'hff, 8'h00);
        issue(OPC_STORE, 8'd0, 8'd4, 8'hff);
        issue(OPC_LOAD, 8'd0, 8'd0, 8'h00);

        // Random phases, each with its own code length and idling mix
        n_items = 0;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       cl = 16'd1;
                1:       cl = 16'hffff;
                2:       cl = 16'($urandom_range(2, 255));
                3:       cl = 16'($urandom_range(257, 65534));
                default: cl = CODE_LENGTH_RST;
            endcase
            write_code_length(cl);
            gap_pct   = GAP_PCT[ph];
            stall_pct = STALL_PCT[ph];
            if (ph == PHASES - 1) hold_req <= 1'b1;
            phase_end = (ph + 1) * PHASE_ITEMS;
            while (n_items < phase_end) begin
                random_sequence();
                if (ph == 2 && !paused && n_items >= phase_end - PHASE_ITEMS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        // Stop the machine once, then beats it must answer as stopped
        gap_pct   = 16;
        stall_pct = 16;
        stop_machine();
        repeat (40) send_beat(8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), 8'($urandom_range(255)));
        instr_ch.valid <= 1'b0;

        waited = 0;
        do begin
            @(negedge clk);
            waited++;
        end while (pending != 0 && waited < 20000);
        repeat (8) @(posedge clk);
        if (pending != 0) $error("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/brvm_pkg.sv
rtl/brvm_if.sv
rtl/brvm_front.sv
rtl/brvm_back.sv
rtl/byte_register_vm_execute_unit.sv
rtl/brvm_checker.sv
tb/brvm_exec_monitor.sv
tb/tb_byte_register_vm_execute_unit.sv
